// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helper macros, compiled out when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ZCPF_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("zcpf assertion failed");
`define ZCPF_ASSERT_NEXT(lbl, clk, rstn, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
    else $error("zcpf assertion failed");
`else
`define ZCPF_ASSERT(lbl, clk, rstn, prop)
`define ZCPF_ASSERT_NEXT(lbl, clk, rstn, pre, post)
`endif

`endif

// ----- hw/rtl/zcpf_pkg.sv -----
// ----------------------------------------------------------------------------
// zcpf_pkg
// shared types and constants of the zero-crossing firing control
// ----------------------------------------------------------------------------
`default_nettype none

package zcpf_pkg;

  localparam int unsigned AVG_DEPTH_DEF = 20;

  localparam int unsigned SAMPLE_W = 10;
  localparam int unsigned TS_W     = 32;
  localparam int unsigned FRAC_W   = 16;
  localparam int unsigned SCALE_W  = 16;
  localparam int unsigned MS_W     = 16;
  localparam int unsigned HZ_W     = 21;
  localparam int unsigned FREQ_W   = 29;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [TS_W-1:0]     FREQ_NUM      = 32'd512000000;
  localparam logic [FREQ_W-1:0]   AVG_RESET_Q8  = 29'd15360;
  localparam logic [SAMPLE_W-1:0] MID_RESET     = 10'd512;
  localparam logic [FRAC_W-1:0]   FRAC_RESET    = 16'd16384;
  localparam logic [SCALE_W-1:0]  SCALE_RESET   = 16'd7680;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIDLEVEL        = 2'd0,
    CFG_FIRING_FRACTION = 2'd1,
    CFG_DELAY_SCALE     = 2'd2
  } cfg_idx_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_SAMPLE,
    OP_DIV_STEP,
    OP_PUSH,
    OP_AVG_SET,
    OP_TICK_INC,
    OP_TICK_MUL,
    OP_TICK_CMP,
    OP_OUT_LOAD
  } op_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic is_tick;
    logic rising;
    logic ts_ok;
    logic armed;
    logic div_last;
  } status_t;

endpackage

`default_nettype wire

// ----- hw/rtl/zcpf_if.sv -----
// ----------------------------------------------------------------------------
// zcpf_if
// valid/ready channel interfaces for input, result and configuration
// ----------------------------------------------------------------------------
`default_nettype none

interface zcpf_in_if import zcpf_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                action;
  logic [SAMPLE_W-1:0] sample;
  logic [TS_W-1:0]     timestamp;
  modport source (output valid, action, sample, timestamp, input ready);
  modport sink   (input valid, action, sample, timestamp, output ready);
endinterface

interface zcpf_out_if import zcpf_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            fire;
  logic            crossing;
  logic            updated;
  logic [HZ_W-1:0] average_hz;
  modport source (output valid, fire, crossing, updated, average_hz, input ready);
  modport sink   (input valid, fire, crossing, updated, average_hz, output ready);
endinterface

interface zcpf_cfg_if import zcpf_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/zcpf_ctrl.sv -----
// ----------------------------------------------------------------------------
// zcpf_ctrl
// sequencer: steps the datapath through sample, division and tick work
// ----------------------------------------------------------------------------
`default_nettype none

module zcpf_ctrl import zcpf_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  input  wire logic    out_ready_i,
  output logic         out_valid_o,
  input  wire status_t status_i,
  output cmd_t         cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_EVAL, S_DIV_FREQ, S_PUSH, S_DIV_AVG, S_AVG_SET,
    S_TICK_INC, S_TICK_MUL, S_TICK_CMP, S_FINISH
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  assign slot_free   = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d    = state_q;
    cmd_o.op   = OP_NONE;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = S_EVAL;
        end
      end
      S_EVAL: begin
        if (status_i.is_tick) begin
          state_d = status_i.armed ? S_TICK_INC : S_FINISH;
        end else begin
          cmd_o.op = OP_SAMPLE;
          state_d  = (status_i.rising && status_i.ts_ok) ? S_DIV_FREQ : S_FINISH;
        end
      end
      S_DIV_FREQ: begin
        cmd_o.op = OP_DIV_STEP;
        if (status_i.div_last) state_d = S_PUSH;
      end
      S_PUSH: begin
        cmd_o.op = OP_PUSH;
        state_d  = S_DIV_AVG;
      end
      S_DIV_AVG: begin
        cmd_o.op = OP_DIV_STEP;
        if (status_i.div_last) state_d = S_AVG_SET;
      end
      S_AVG_SET: begin
        cmd_o.op = OP_AVG_SET;
        state_d  = S_FINISH;
      end
      S_TICK_INC: begin
        cmd_o.op = OP_TICK_INC;
        state_d  = S_TICK_MUL;
      end
      S_TICK_MUL: begin
        cmd_o.op = OP_TICK_MUL;
        state_d  = S_TICK_CMP;
      end
      S_TICK_CMP: begin
        cmd_o.op = OP_TICK_CMP;
        state_d  = S_FINISH;
      end
      S_FINISH: begin
        if (slot_free) begin
          cmd_o.op    = OP_OUT_LOAD;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/zcpf_dp.sv -----
// ----------------------------------------------------------------------------
// zcpf_dp
// datapath: config registers, frequency ring, shared divider, firing compare
// ----------------------------------------------------------------------------
`default_nettype none

module zcpf_dp import zcpf_pkg::*; #(
  parameter int unsigned AVG_DEPTH = AVG_DEPTH_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire cmd_t                  cmd_i,
  output status_t                    status_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  in_action_i,
  input  wire logic [SAMPLE_W-1:0]   in_sample_i,
  input  wire logic [TS_W-1:0]       in_timestamp_i,
  output logic                       fire_o,
  output logic                       crossing_o,
  output logic                       updated_o,
  output logic [HZ_W-1:0]            average_hz_o
);

  localparam int unsigned PosW   = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
  localparam int unsigned FillW  = $clog2(AVG_DEPTH + 1);
  localparam int unsigned TotalW = FREQ_W + FillW;
  localparam int unsigned CntW   = $clog2(TotalW);
  localparam int unsigned ProdW  = MS_W + FREQ_W;
  localparam int unsigned LhsW   = ProdW + 8;
  localparam int unsigned RhsW   = SCALE_W + FRAC_W;

  logic [SAMPLE_W-1:0] mid_q;
  logic [FRAC_W-1:0]   frac_q;
  logic [SCALE_W-1:0]  scale_q;

  logic                action_q;
  logic [SAMPLE_W-1:0] sample_q;
  logic [TS_W-1:0]     ts_q;

  logic                last_above_q;
  logic [TS_W-1:0]     last_cap_q;
  logic [FREQ_W-1:0]   ring_q [AVG_DEPTH];
  logic [PosW-1:0]     pos_q;
  logic [FillW-1:0]    fill_q;
  logic [TotalW-1:0]   total_q;
  logic [FREQ_W-1:0]   avg_q;
  logic                armed_q;
  logic [MS_W-1:0]     ms_q;

  logic [TotalW-1:0]   dq_q;
  logic [TS_W-1:0]     rem_q;
  logic [TS_W-1:0]     dvs_q;
  logic [CntW-1:0]     cnt_q;

  logic [ProdW-1:0]    prod_q;
  logic [RhsW-1:0]     rhs_q;

  logic res_fire_q, res_cross_q, res_upd_q;

  logic              above, rising;
  logic [TS_W-1:0]   elapsed, divisor;
  logic [TS_W:0]     rem_shift;
  logic              q_bit;
  logic [FREQ_W-1:0] new_freq;
  logic [TotalW-1:0] total_new;
  logic [FillW-1:0]  fill_new;
  logic              fire_hit;

  assign above     = (sample_q >= mid_q);
  assign rising    = !last_above_q && above;
  assign elapsed   = ts_q - last_cap_q;
  assign divisor   = (elapsed == '0) ? TS_W'(1) : elapsed;
  assign rem_shift = {rem_q, dq_q[TotalW-1]};
  assign q_bit     = (rem_shift >= {1'b0, dvs_q});
  assign new_freq  = dq_q[FREQ_W-1:0];
  assign total_new = total_q - TotalW'(ring_q[pos_q]) + TotalW'(new_freq);
  assign fill_new  = (fill_q < FillW'(AVG_DEPTH)) ? fill_q + FillW'(1) : fill_q;
  assign fire_hit  = (avg_q != '0) && ({prod_q, 8'd0} >= LhsW'(rhs_q));

  assign status_o.is_tick  = action_q;
  assign status_o.rising   = rising;
  assign status_o.ts_ok    = (ts_q >= last_cap_q);
  assign status_o.armed    = armed_q;
  assign status_o.div_last = (cnt_q == CntW'(TotalW - 1));

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_q   <= MID_RESET;
      frac_q  <= FRAC_RESET;
      scale_q <= SCALE_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_MIDLEVEL:        mid_q   <= cfg_data_i[SAMPLE_W-1:0];
        CFG_FIRING_FRACTION: frac_q  <= cfg_data_i[FRAC_W-1:0];
        CFG_DELAY_SCALE:     scale_q <= cfg_data_i[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // item payload and working registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        action_q <= in_action_i;
        sample_q <= in_sample_i;
        ts_q     <= in_timestamp_i;
      end
      OP_SAMPLE: begin
        dq_q  <= TotalW'(FREQ_NUM);
        dvs_q <= divisor;
        rem_q <= '0;
        cnt_q <= '0;
      end
      OP_DIV_STEP: begin
        rem_q <= TS_W'(q_bit ? rem_shift - {1'b0, dvs_q} : rem_shift);
        dq_q  <= {dq_q[TotalW-2:0], q_bit};
        cnt_q <= cnt_q + CntW'(1);
      end
      OP_PUSH: begin
        dq_q  <= total_new;
        dvs_q <= TS_W'(fill_new);
        rem_q <= '0;
        cnt_q <= '0;
      end
      OP_TICK_MUL: begin
        prod_q <= ProdW'(ms_q) * ProdW'(avg_q);
        rhs_q  <= RhsW'(scale_q) * RhsW'(frac_q);
      end
      OP_OUT_LOAD: begin
        fire_o       <= res_fire_q;
        crossing_o   <= res_cross_q;
        updated_o    <= res_upd_q;
        average_hz_o <= avg_q[FREQ_W-1:8];
      end
      default: ;
    endcase
  end

  // block state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_above_q <= 1'b0;
      last_cap_q   <= '0;
      for (int i = 0; i < AVG_DEPTH; i++) ring_q[i] <= '0;
      pos_q        <= '0;
      fill_q       <= '0;
      total_q      <= '0;
      avg_q        <= AVG_RESET_Q8;
      armed_q      <= 1'b0;
      ms_q         <= '0;
      res_fire_q   <= 1'b0;
      res_cross_q  <= 1'b0;
      res_upd_q    <= 1'b0;
    end else begin
      case (cmd_i.op)
        OP_LOAD: begin
          res_fire_q  <= 1'b0;
          res_cross_q <= 1'b0;
          res_upd_q   <= 1'b0;
        end
        OP_SAMPLE: begin
          last_above_q <= above;
          res_cross_q  <= rising;
        end
        OP_PUSH: begin
          ring_q[pos_q] <= new_freq;
          total_q       <= total_new;
          pos_q         <= (pos_q == PosW'(AVG_DEPTH - 1)) ? '0 : pos_q + PosW'(1);
          fill_q        <= fill_new;
          last_cap_q    <= ts_q;
          armed_q       <= 1'b1;
          res_upd_q     <= 1'b1;
        end
        OP_AVG_SET: avg_q <= dq_q[FREQ_W-1:0];
        OP_TICK_INC: begin
          if (ms_q != '1) ms_q <= ms_q + MS_W'(1);
        end
        OP_TICK_CMP: begin
          if (fire_hit) begin
            res_fire_q <= 1'b1;
            armed_q    <= 1'b0;
            ms_q       <= '0;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/zero_cross_phase_fire_control_top.sv -----
// ----------------------------------------------------------------------------
// zero_cross_phase_fire_control_top
// zero-crossing phase-angle firing control, sequencer plus datapath
// ----------------------------------------------------------------------------
// channels: in_i takes an ADC sample with its 2 MHz timestamp (action 0) or
// a 1 ms firing tick (action 1); out_o returns one result per item with
// fire, crossing, updated and the integer average frequency; cfg_i writes
// the midpoint level (0), firing_fraction (1) and delay_scale (2), always ready.
// one item is in work at a time; in_i.ready is high only when idle.
// a sample without an update and a disarmed tick go from evaluation straight
// to the result; an armed tick adds the increment, multiply and compare steps;
// a crossing that updates the average runs the bit-serial divider, shared by
// the period and the average division, over W = 29 + clog2(AVG_DEPTH+1)
// quotient bits for each division, with the ring push between the two.
// a finished result waits in the output register; the next item is taken
// while it waits, and is held in its last step until out_o.ready frees
// the register.
// reset clears the ring, the sum and the timing state, sets the average to
// 60 Hz and the registers to their defaults.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module zero_cross_phase_fire_control_top import zcpf_pkg::*; #(
  parameter int unsigned AVG_DEPTH = AVG_DEPTH_DEF
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  zcpf_in_if.sink    in_i,
  zcpf_out_if.source out_o,
  zcpf_cfg_if.sink   cfg_i
);

  cmd_t    cmd;
  status_t status;

  assign cfg_i.ready = 1'b1;

  zcpf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  zcpf_dp #(
    .AVG_DEPTH (AVG_DEPTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .cfg_we_i       (cfg_i.valid),
    .cfg_index_i    (cfg_i.index),
    .cfg_data_i     (cfg_i.data),
    .in_action_i    (in_i.action),
    .in_sample_i    (in_i.sample),
    .in_timestamp_i (in_i.timestamp),
    .fire_o         (out_o.fire),
    .crossing_o     (out_o.crossing),
    .updated_o      (out_o.updated),
    .average_hz_o   (out_o.average_hz)
  );

  `ZCPF_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_i.valid && in_i.ready, !in_i.ready)
  `ZCPF_ASSERT(a_load_slot_free, clk_i, rst_ni, (cmd.op != OP_OUT_LOAD) || !out_o.valid || out_o.ready)
  `ZCPF_ASSERT(a_upd_needs_cross, clk_i, rst_ni, !out_o.valid || !out_o.updated || out_o.crossing)
  `ZCPF_ASSERT(a_fire_is_tick, clk_i, rst_ni, !out_o.valid || !out_o.fire || !out_o.crossing)

endmodule

`default_nettype wire

// ----- bench/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the zero-crossing phase-angle firing control
// ----------------------------------------------------------------------------
// A table of directed items runs first: the reset state, full-scale
// samples, a zero and a maximal period, a timestamp running backwards and
// ticks with the block armed and idle. Random waveform periods with firing
// ticks follow, mixed with noise items. Each phase uses other register
// values, and the phases vary the idling on both channels. Every result is
// compared with its table entry or the output of an in-bench model of the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
  import zcpf_pkg::*;

  localparam int DEPTH = 20;
  localparam int DRAIN_CYC = 100;
  localparam int PHASE_ITEMS = 210;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef struct packed {
    logic            fire;
    logic            crossing;
    logic            updated;
    logic [HZ_W-1:0] hz;
  } firing_res_t;

  typedef struct packed {
    logic                action;
    logic [SAMPLE_W-1:0] smp;
    logic [TS_W-1:0]     ts;
    logic                typed;
    firing_res_t         res;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  zcpf_in_if  in_if();
  zcpf_out_if out_if();
  zcpf_cfg_if cfg_if();

  zero_cross_phase_fire_control_top dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // block state as seen by the model
  logic [SAMPLE_W-1:0] mid_q;
  logic [FRAC_W-1:0]   frac_q;
  logic [SCALE_W-1:0]  scale_q;
  logic                above_q;
  logic [TS_W-1:0]     capture_q;
  logic [31:0]         ring_q [DEPTH];
  int unsigned         pos_q;
  int unsigned         fill_q;
  logic [36:0]         total_q;
  logic [31:0]         avg_q8;
  logic                armed_q;
  logic [MS_W-1:0]     ms_q;

  firing_res_t expected_q[$];
  int errors = 0;
  int src_idle = 0;
  int snk_stall = 0;
  int sent = 0;

  function automatic firing_res_t next_result(logic act, logic [SAMPLE_W-1:0] smp,
                                              logic [TS_W-1:0] ts);
    firing_res_t r;
    logic [TS_W-1:0] span;
    logic [31:0] freq;
    logic [63:0] lhs, rhs;
    r = '0;
    if (!act) begin
      if (!above_q && smp >= mid_q) begin
        r.crossing = 1'b1;
        if (ts >= capture_q) begin
          span = ts - capture_q;
          if (span == 0) span = 1;
          freq = FREQ_NUM / span;
          total_q = total_q - ring_q[pos_q] + freq;
          ring_q[pos_q] = freq;
          pos_q = (pos_q + 1) % DEPTH;
          if (fill_q < DEPTH) fill_q++;
          avg_q8 = 32'(total_q / fill_q);
          capture_q = ts;
          armed_q = 1'b1;
          r.updated = 1'b1;
        end
      end
      above_q = smp >= mid_q;
    end else if (armed_q) begin
      if (ms_q != 16'hFFFF) ms_q++;
      lhs = 64'(ms_q) * 64'(avg_q8) * 64'd256;
      rhs = 64'(scale_q) * 64'(frac_q);
      if (avg_q8 != 0 && lhs >= rhs) begin
        r.fire = 1'b1;
        armed_q = 1'b0;
        ms_q = '0;
      end
    end
    r.hz = avg_q8[28:8];
    return r;
  endfunction

  task automatic send_item(logic act, logic [SAMPLE_W-1:0] smp, logic [TS_W-1:0] ts,
                           logic typed, firing_res_t res);
    firing_res_t p;
    while ($urandom_range(99) < src_idle) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.action    <= act;
    in_if.sample    <= smp;
    in_if.timestamp <= ts;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    p = next_result(act, smp, ts);
    expected_q.push_back(typed ? res : p);
    sent++;
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    case (idx)
      CFG_MIDLEVEL:        mid_q   = val[SAMPLE_W-1:0];
      CFG_FIRING_FRACTION: frac_q  = val;
      CFG_DELAY_SCALE:     scale_q = val;
      default: ;
    endcase
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // random waveform periods with firing ticks, plus noise
  task automatic run_random(int n);
    int stop;
    int unsigned per, k;
    logic [TS_W-1:0] now;
    logic [SAMPLE_W-1:0] lo, hi;
    stop = sent + n;
    now = $urandom;
    while (sent < stop) begin
      if ($urandom_range(99) < 15) begin
        send_item($urandom_range(1), $urandom, $urandom, 1'b0, '0);
        continue;
      end
      case ($urandom_range(9))
        0: per = $urandom_range(1 << 20);
        1: per = 0;
        2: per = $urandom;
        default: per = $urandom_range(30000, 40000);
      endcase
      if ($urandom_range(19) == 0) now = now - $urandom_range(1 << 16);
      else now = now + per;
      lo = (mid_q == 0) ? 10'd0 : 10'($urandom_range(mid_q - 1));
      hi = 10'($urandom_range(1023, mid_q));
      send_item(1'b0, lo, now - 5, 1'b0, '0);
      send_item(1'b0, hi, now, 1'b0, '0);
      k = $urandom_range(3);
      repeat (k) send_item(1'b0, 10'($urandom_range(1023, mid_q)), now + 7, 1'b0, '0);
      k = $urandom_range(60);
      repeat (k) send_item(1'b1, $urandom, $urandom, 1'b0, '0);
      if (sent > stop - n / 2 && sent < stop - n / 2 + 8) begin
        in_if.valid <= 1'b0;
        @(posedge clk_i);
        while (expected_q.size() != 0) @(posedge clk_i);
      end
    end
  endtask

  dir_row_t dir_tab [15] = '{
    '{1'b1, 10'd0,    32'd0,          1'b1, '{1'b0, 1'b0, 1'b0, 21'd60}},
    '{1'b0, 10'd0,    32'd0,          1'b1, '{1'b0, 1'b0, 1'b0, 21'd60}},
    '{1'b0, 10'd1023, 32'd1,          1'b1, '{1'b0, 1'b1, 1'b1, 21'd2000000}},
    '{1'b1, 10'd0,    32'd0,          1'b1, '{1'b1, 1'b0, 1'b0, 21'd2000000}},
    '{1'b1, 10'd1023, 32'hFFFF_FFFF,  1'b1, '{1'b0, 1'b0, 1'b0, 21'd2000000}},
    '{1'b0, 10'd511,  32'd100,        1'b1, '{1'b0, 1'b0, 1'b0, 21'd2000000}},
    '{1'b0, 10'd512,  32'd0,          1'b1, '{1'b0, 1'b1, 1'b0, 21'd2000000}},
    '{1'b0, 10'd512,  32'd60,         1'b1, '{1'b0, 1'b0, 1'b0, 21'd2000000}},
    '{1'b0, 10'd0,    32'd70,         1'b1, '{1'b0, 1'b0, 1'b0, 21'd2000000}},
    '{1'b0, 10'd1023, 32'hFFFF_FFFF,  1'b1, '{1'b0, 1'b1, 1'b1, 21'd1000000}},
    '{1'b0, 10'd0,    32'hFFFF_FFFF,  1'b1, '{1'b0, 1'b0, 1'b0, 21'd1000000}},
    '{1'b0, 10'd700,  32'hFFFF_FFFF,  1'b1, '{1'b0, 1'b1, 1'b1, 21'd1333333}},
    '{1'b1, 10'd0,    32'd0,          1'b1, '{1'b1, 1'b0, 1'b0, 21'd1333333}},
    '{1'b0, 10'd5,    32'h5555_AAAA,  1'b0, '0},
    '{1'b0, 10'd1023, 32'd33338,      1'b0, '0}
  };

  always @(posedge clk_i) begin
    out_if.ready <= ($urandom_range(99) >= snk_stall);
  end

  // result checking
  always @(posedge clk_i) begin
    firing_res_t e;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result transfer");
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (out_if.fire !== e.fire) begin
          $error("fire: expected %0d, got %0d", e.fire, out_if.fire);
          errors++;
        end
        if (out_if.crossing !== e.crossing) begin
          $error("crossing: expected %0d, got %0d", e.crossing, out_if.crossing);
          errors++;
        end
        if (out_if.updated !== e.updated) begin
          $error("updated: expected %0d, got %0d", e.updated, out_if.updated);
          errors++;
        end
        if (out_if.average_hz !== e.hz) begin
          $error("average_hz: expected %0d, got %0d", e.hz, out_if.average_hz);
          errors++;
        end
      end
    end
  end

  initial begin
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    rst_ni = 1'b0;
    in_if.valid <= 1'b0;
    in_if.action <= 1'b0;
    in_if.sample <= '0;
    in_if.timestamp <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= CFG_MIDLEVEL;
    cfg_if.data <= '0;
    mid_q = MID_RESET;
    frac_q = FRAC_RESET;
    scale_q = SCALE_RESET;
    above_q = 1'b0;
    capture_q = '0;
    foreach (ring_q[i]) ring_q[i] = '0;
    pos_q = 0;
    fill_q = 0;
    total_q = '0;
    avg_q8 = 32'(AVG_RESET_Q8);
    armed_q = 1'b0;
    ms_q = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i])
      send_item(dir_tab[i].action, dir_tab[i].smp, dir_tab[i].ts, dir_tab[i].typed,
                dir_tab[i].res);
    run_random(PHASE_ITEMS);
    drain();

    write_reg(CFG_MIDLEVEL, 16'hFFFF);
    write_reg(CFG_FIRING_FRACTION, 16'd0);
    write_reg(CFG_DELAY_SCALE, 16'd0);
    write_reg(CFG_UNUSED, 16'h1234);
    src_idle = 51;
    run_random(PHASE_ITEMS);
    drain();

    write_reg(CFG_MIDLEVEL, 16'd0);
    write_reg(CFG_FIRING_FRACTION, 16'hFFFF);
    write_reg(CFG_DELAY_SCALE, 16'hFFFF);
    src_idle = 0;
    snk_stall = 51;
    run_random(PHASE_ITEMS);
    drain();

    write_reg(CFG_MIDLEVEL, 16'd300);
    write_reg(CFG_FIRING_FRACTION, 16'h8000);
    write_reg(CFG_DELAY_SCALE, 16'd7680);
    src_idle = 15;
    snk_stall = 15;
    run_random(PHASE_ITEMS);
    drain();

    write_reg(CFG_MIDLEVEL, 16'd512);
    write_reg(CFG_FIRING_FRACTION, 16'd16384);
    write_reg(CFG_DELAY_SCALE, 16'hFFFF);
    src_idle = 0;
    snk_stall = 0;
    run_random(PHASE_ITEMS);
    drain();

    write_reg(CFG_MIDLEVEL, 16'd900);
    write_reg(CFG_FIRING_FRACTION, 16'd1);
    write_reg(CFG_DELAY_SCALE, 16'd1);
    src_idle = 51;
    snk_stall = 51;
    run_random(PHASE_ITEMS);
    drain();

    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
